/* src/vector_normalize_top_assert.svh */
// assertion macros shared by the vector normalize rtl
`ifndef VECTOR_NORMALIZE_TOP_ASSERT_SVH
`define VECTOR_NORMALIZE_TOP_ASSERT_SVH

// condition on one cycle implies a condition on the same cycle
`define VN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition on one cycle implies a condition on the next cycle
`define VN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/vn_pkg.sv */
`default_nettype none
package vn_pkg;

  localparam int LANES        = 4;
  localparam int MAX_DIM      = 4;
  localparam int CAP          = (MAX_DIM < LANES) ? MAX_DIM : LANES;
  localparam int OUT_FRAC     = 30;
  localparam int FRAC_STEPS   = OUT_FRAC - 1;
  localparam int DIV_STAGES   = 2 + FRAC_STEPS + 1;
  localparam int SQRT_STAGES  = 32;
  localparam int FRONT_STAGES = 10;
  localparam int TOTAL_STAGES = FRONT_STAGES + SQRT_STAGES + 1 + DIV_STAGES;
  localparam logic [32:0] UNIT_MAX = 33'(1) << OUT_FRAC;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DIM   = 2'd1,
    ST_ZERO_LEN = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         dim_count;
    logic signed [31:0] elem_a;
    logic signed [31:0] elem_b;
    logic signed [31:0] elem_c;
    logic signed [31:0] elem_d;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] unit_a;
    logic signed [31:0] unit_b;
    logic signed [31:0] unit_c;
    logic signed [31:0] unit_d;
  } out_item_t;

  typedef struct packed {
    logic [LANES-1:0][31:0] mag;
    logic [LANES-1:0]       neg;
    logic [LANES-1:0]       used;
    status_t                st;
    logic                   big;
    logic [4:0]             sh;
  } side_t;

endpackage
`default_nettype wire

/* src/vn_isqrt.sv */
`default_nettype none
module vn_isqrt import vn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [63:0] n_in,
  output logic      [31:0] len
);

  logic [63:0] rem_r [SQRT_STAGES];
  logic [63:0] res_r [SQRT_STAGES];

  // one result bit per stage, bit weights walk down from 2^62
  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_st
    logic [63:0] rem_in, res_in, bitv;
    logic [64:0] t;
    logic        ge;
    if (i == 0) begin : g_first
      assign rem_in = n_in;
      assign res_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[i-1];
      assign res_in = res_r[i-1];
    end
    assign bitv = 64'(1) << (62 - 2 * i);
    assign t    = {1'b0, res_in} + {1'b0, bitv};
    assign ge   = {1'b0, rem_in} >= t;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ge) begin
          rem_r[i] <= rem_in - t[63:0];
          res_r[i] <= (res_in >> 1) + bitv;
        end else begin
          rem_r[i] <= rem_in;
          res_r[i] <= res_in >> 1;
        end
      end
    end
  end

  assign len = res_r[SQRT_STAGES-1][31:0];

endmodule
`default_nettype wire

/* src/vn_lane_div.sv */
`default_nettype none
module vn_lane_div import vn_pkg::*; (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic        [33:0] num,
  input  wire logic        [31:0] den,
  input  wire logic               en,
  input  wire logic               neg,
  output logic signed      [31:0] unit
);

  localparam int STEPS = DIV_STAGES - 1;

  logic [33:0] r_r   [STEPS];
  logic [31:0] q_r   [STEPS];
  logic [31:0] den_r [STEPS];
  logic        en_r  [STEPS];
  logic        neg_r [STEPS];
  logic [31:0] unit_r;

  // two integer quotient steps, then one fraction bit per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_st
    logic [33:0] rem_in, cmpv;
    logic [31:0] q_in, dv;
    logic        e_in, n_in, ge;
    if (j == 0) begin : g_first
      assign rem_in = num;
      assign q_in   = '0;
      assign dv     = den;
      assign e_in   = en;
      assign n_in   = neg;
      assign cmpv   = {1'b0, den, 1'b0};
    end else begin : g_rest
      assign q_in   = q_r[j-1];
      assign dv     = den_r[j-1];
      assign e_in   = en_r[j-1];
      assign n_in   = neg_r[j-1];
      assign cmpv   = {2'b00, den_r[j-1]};
      if (j == 1) begin : g_int
        assign rem_in = r_r[j-1];
      end else begin : g_frac
        assign rem_in = {r_r[j-1][32:0], 1'b0};
      end
    end
    assign ge = rem_in >= cmpv;
    always_ff @(posedge clk) begin
      if (adv) begin
        r_r[j]   <= ge ? (rem_in - cmpv) : rem_in;
        den_r[j] <= dv;
        en_r[j]  <= e_in;
        neg_r[j] <= n_in;
        if (j == 0) begin
          q_r[j] <= {30'b0, ge, 1'b0};
        end else if (j == 1) begin
          q_r[j] <= {q_in[31:1], ge};
        end else begin
          q_r[j] <= {q_in[30:0], ge};
        end
      end
    end
  end

  logic        rnd;
  logic [32:0] qr, sat;

  always_comb begin
    rnd = {r_r[STEPS-1], 1'b0} >= {3'b000, den_r[STEPS-1]};
    qr  = {1'b0, q_r[STEPS-1]} + {32'b0, rnd};
    sat = (qr > UNIT_MAX) ? UNIT_MAX : qr;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!en_r[STEPS-1]) begin
        unit_r <= '0;
      end else if (neg_r[STEPS-1]) begin
        unit_r <= 32'(-sat);
      end else begin
        unit_r <= sat[31:0];
      end
    end
  end

  assign unit = unit_r;

endmodule
`default_nettype wire

/* src/vector_normalize_top.sv */
// vector normalize: takes up to four signed q16.16 elements and a count, returns the
// unit vector in signed q2.30 plus a status (ok, no dimension, zero length). one
// item transfer per cycle in and out, as long as no stall holds the flow. the path
// runs through the 10 front stages, the 32-stage square-root pipeline, one numerator
// stage and the 32-stage per-lane divider, plus the output register; four divider
// lanes run side by side. the output has a two-entry skid, so in_stall rises in the
// cycle after a new result meets a stalled output.
`default_nettype none
`include "vector_normalize_top_assert.svh"
module vector_normalize_top import vn_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // pipeline advances as a whole while the skid register is empty
  logic skid_v_r;
  logic adv, in_acc;
  assign adv    = !skid_v_r;
  assign in_acc = in_valid && adv;
  assign in_stall = skid_v_r;

  logic [TOTAL_STAGES-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[TOTAL_STAGES-2:0], in_acc};
    end
  end

  // stage a: magnitudes, signs, used lanes
  logic [LANES-1:0][31:0] elem;
  side_t                  side_a;
  assign elem[0] = in_data.elem_a;
  assign elem[1] = in_data.elem_b;
  assign elem[2] = in_data.elem_c;
  assign elem[3] = in_data.elem_d;

  always_comb begin
    side_a     = '0;
    side_a.st  = (in_data.dim_count == 3'd0) ? ST_NO_DIM : ST_OK;
    for (int i = 0; i < LANES; i++) begin
      side_a.neg[i]  = elem[i][31];
      side_a.mag[i]  = elem[i][31] ? 32'(-elem[i]) : elem[i];
      side_a.used[i] = (3'(i) < in_data.dim_count) && (i < CAP);
    end
  end

  side_t       sd_r [FRONT_STAGES];
  side_t       sd_nxt [FRONT_STAGES];
  logic [63:0] sq_r [LANES];
  logic [63:0] p0_r, p1_r;
  logic [64:0] sum_r;
  logic [63:0] nrm_r [6];
  logic [5:1]  norm_hit;

  always_comb begin
    sd_nxt[0] = side_a;
    for (int k = 1; k < FRONT_STAGES; k++) begin
      sd_nxt[k] = sd_r[k-1];
    end
    // sum of 2^64 or more gets a right shift by two instead
    sd_nxt[4].big = sum_r[64];
    sd_nxt[4].sh  = '0;
    if (sd_r[3].st == ST_OK && sum_r == '0) begin
      sd_nxt[4].st = ST_ZERO_LEN;
    end
    // shift count grows by half of each normalize step taken
    for (int k = 1; k <= 5; k++) begin
      if (norm_hit[k]) begin
        sd_nxt[4+k].sh = sd_r[3+k].sh + 5'(32 >> k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r <= sd_nxt;
      // squares, one multiplier per lane
      for (int i = 0; i < LANES; i++) begin
        sq_r[i] <= sd_r[0].used[i] ? (64'(sd_r[0].mag[i]) * 64'(sd_r[0].mag[i])) : 64'd0;
      end
      // two-level adder tree
      p0_r  <= sq_r[0] + sq_r[1];
      p1_r  <= sq_r[2] + sq_r[3];
      sum_r <= {1'b0, p0_r} + {1'b0, p1_r};
      nrm_r[0] <= sum_r[64] ? {1'b0, sum_r[64:2]} : sum_r[63:0];
    end
  end

  // leading zero pairs removed in 32, 16, 8, 4, 2 bit steps
  for (genvar k = 1; k <= 5; k++) begin : g_norm
    localparam int W = 64 >> k;
    assign norm_hit[k] = !sd_r[3+k].big && (nrm_r[k-1][63 -: W] == '0);
    always_ff @(posedge clk) begin
      if (adv) begin
        nrm_r[k] <= norm_hit[k] ? (nrm_r[k-1] << W) : nrm_r[k-1];
      end
    end
  end

  // square root, side data delayed alongside
  logic [31:0] len;
  side_t       ss_r [SQRT_STAGES];

  vn_isqrt u_isqrt (
    .clk  (clk),
    .adv  (adv),
    .n_in (nrm_r[5]),
    .len  (len)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_r[0] <= sd_r[FRONT_STAGES-1];
      for (int k = 1; k < SQRT_STAGES; k++) begin
        ss_r[k] <= ss_r[k-1];
      end
    end
  end

  // numerator prep: magnitude scaled by 2^(s+1), so every lane runs the same steps
  side_t            sl;
  logic [5:0]       shamt;
  logic [LANES-1:0][33:0] num_r;
  logic [LANES-1:0] en_r, neg_r;
  logic [31:0]      den_r;
  status_t          st_p_r;

  assign sl    = ss_r[SQRT_STAGES-1];
  assign shamt = sl.big ? 6'd0 : ({1'b0, sl.sh} + 6'd1);

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r  <= len;
      st_p_r <= sl.st;
      for (int i = 0; i < LANES; i++) begin
        num_r[i] <= 34'({32'b0, sl.mag[i]} << shamt);
        en_r[i]  <= sl.used[i] && (sl.st == ST_OK);
        neg_r[i] <= sl.neg[i];
      end
    end
  end

  // divider lanes
  logic [LANES-1:0][31:0] unit;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vn_lane_div u_div (
      .clk  (clk),
      .adv  (adv),
      .num  (num_r[i]),
      .den  (den_r),
      .en   (en_r[i]),
      .neg  (neg_r[i]),
      .unit (unit[i])
    );
  end

  status_t st_d_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      st_d_r[0] <= st_p_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        st_d_r[k] <= st_d_r[k-1];
      end
    end
  end

  // merge lanes and status into one result
  out_item_t merged;
  always_comb begin
    merged.status = st_d_r[DIV_STAGES-1];
    merged.unit_a = unit[0];
    merged.unit_b = unit[1];
    merged.unit_c = unit[2];
    merged.unit_d = unit[3];
  end

  // output register plus skid entry
  logic      out_valid_r;
  out_item_t out_data_r, skid_data_r;
  logic      push, take;
  assign push = adv && v_r[TOTAL_STAGES-1];
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (take || !out_valid_r) begin
        out_data_r  <= skid_data_r;
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end
    end else if (push) begin
      if (take || !out_valid_r) begin
        out_data_r  <= merged;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r <= merged;
        skid_v_r    <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VN_ASSERT_IMPL(a_skid_has_out, skid_v_r, out_valid_r, "skid entry without output entry")
  `VN_ASSERT_NEXT(a_skid_fill, out_valid_r && out_stall && push, skid_v_r, "result dropped on stall")
  `VN_ASSERT_IMPL(a_bad_status_zero,
    out_valid_r && (out_data_r.status != ST_OK),
    (out_data_r.unit_a == '0) && (out_data_r.unit_b == '0) &&
    (out_data_r.unit_c == '0) && (out_data_r.unit_d == '0),
    "nonzero unit on failed status")

endmodule
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vn_pkg::*;

  // expected unit vectors, oldest first, with the normalization arithmetic
  class unit_vector_board;
    out_item_t pending_units[$];
    int unsigned mismatch_count;
    int unsigned checked_count;

    static function logic [63:0] root_of(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    static function logic [63:0] ratio_of(logic [63:0] mag, int shift, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = mag / den;
      r = mag % den;
      for (int k = 0; k < shift; k++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q[0] = 1'b1;
        end
      end
      if ((r << 1) >= den) q = q + 1;
      if (q > 64'(UNIT_MAX)) q = 64'(UNIT_MAX);
      return q;
    endfunction

    static function out_item_t normalize(in_item_t it);
      out_item_t res;
      logic [31:0] elems [LANES];
      logic [31:0] units [LANES];
      logic [63:0] mag [LANES];
      logic [LANES-1:0] neg;
      logic [63:0] hi, lo, sq, norm, len;
      int n, s;
      res = '0;
      hi = 0;
      lo = 0;
      s = 0;
      elems[0] = it.elem_a;
      elems[1] = it.elem_b;
      elems[2] = it.elem_c;
      elems[3] = it.elem_d;
      n = int'(it.dim_count);
      if (n == 0) begin
        res.status = ST_NO_DIM;
        return res;
      end
      if (n > CAP) n = CAP;
      for (int i = 0; i < LANES; i++) begin
        neg[i] = elems[i][31];
        mag[i] = neg[i] ? (64'd1 << 32) - {32'd0, elems[i]} : {32'd0, elems[i]};
        units[i] = 0;
      end
      for (int i = 0; i < n; i++) begin
        sq = mag[i] * mag[i];
        lo = lo + sq;
        if (lo < sq) hi = hi + 1;
      end
      if (hi == 0 && lo == 0) begin
        res.status = ST_ZERO_LEN;
        return res;
      end
      if (hi != 0) begin
        norm = (hi << 62) | (lo >> 2);
        s = -1;
      end else begin
        norm = lo;
        while (norm < (64'd1 << 62)) begin
          norm = norm << 2;
          s++;
        end
      end
      len = root_of(norm);
      for (int i = 0; i < n; i++) begin
        sq = ratio_of(mag[i], OUT_FRAC + s, len);
        units[i] = neg[i] ? 32'(64'd0 - sq) : sq[31:0];
      end
      res.status = ST_OK;
      res.unit_a = units[0];
      res.unit_b = units[1];
      res.unit_c = units[2];
      res.unit_d = units[3];
      return res;
    endfunction

    function void note_vector(in_item_t it);
      pending_units.push_back(normalize(it));
    endfunction

    function void check_unit(out_item_t got);
      out_item_t want;
      checked_count++;
      if (pending_units.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_units.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected st=%0d %h %h %h %h, actual st=%0d %h %h %h %h",
                   want.status, want.unit_a, want.unit_b, want.unit_c, want.unit_d,
                   got.status, got.unit_a, got.unit_b, got.unit_c, got.unit_d);
      end
    endfunction
  endclass

  localparam int RANDOM_VECTORS = 1750;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * TOTAL_STAGES;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  unit_vector_board board;
  in_item_t directed_vectors[$];
  int unsigned sent_count;
  int unsigned idle_cycles;
  bit calm_phase;
  bit stim_done;

  vector_normalize_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // random element: mix of extremes, tiny values and full range
  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 16)) - 8);
      4: return 32'($urandom_range(0, 65535) << $urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_vector();
    in_item_t v;
    v.dim_count = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(1, 4));
    v.elem_a = rand_elem();
    v.elem_b = rand_elem();
    v.elem_c = rand_elem();
    v.elem_d = rand_elem();
    return v;
  endfunction

  function automatic in_item_t mk(int n, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] c, logic [31:0] d);
    in_item_t v;
    v.dim_count = 3'(n);
    v.elem_a = a;
    v.elem_b = b;
    v.elem_c = c;
    v.elem_d = d;
    return v;
  endfunction

  // drive one vector and hold it until the transfer happens
  task automatic send_vector(in_item_t v);
    while (!calm_phase && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_vector(v);
    sent_count++;
  endtask

  // result side: random stall, check on every transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_unit(out_data);
      out_stall <= !calm_phase && ($urandom_range(0, 99) < 22);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (stim_done && board.pending_units.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    sent_count = 0;
    calm_phase = 1'b0;
    stim_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no dimension, zero length, extremes, saturated count, big sum
    directed_vectors.push_back(mk(0, 32'h0001_0000, 0, 0, 0));
    directed_vectors.push_back(mk(4, 0, 0, 0, 0));
    directed_vectors.push_back(mk(2, 0, 0, 32'h1234, 32'h5678));
    directed_vectors.push_back(mk(1, 32'h0001_0000, 0, 0, 0));
    directed_vectors.push_back(mk(1, 32'hffff_0000, 0, 0, 0));
    directed_vectors.push_back(mk(1, 32'd1, 32'hffff_ffff, 0, 0));
    directed_vectors.push_back(mk(1, 32'h8000_0000, 0, 0, 0));
    directed_vectors.push_back(mk(1, 32'h7fff_ffff, 0, 0, 0));
    directed_vectors.push_back(mk(4, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000));
    directed_vectors.push_back(mk(4, 32'h7fff_ffff, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h7fff_ffff));
    directed_vectors.push_back(mk(3, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 5));
    directed_vectors.push_back(mk(2, 32'd3, 32'd4, 0, 0));
    directed_vectors.push_back(mk(2, 32'hffff_fffd, 32'd4, 0, 0));
    directed_vectors.push_back(mk(4, 1, 1, 1, 1));
    directed_vectors.push_back(mk(5, 1, 2, 3, 4));
    directed_vectors.push_back(mk(7, 32'hffff_ffff, 2, 32'hffff_fffd, 4));
    directed_vectors.push_back(mk(6, 0, 0, 0, 0));
    directed_vectors.push_back(mk(3, 0, 0, 0, 32'h7fff_ffff));
    directed_vectors.push_back(mk(4, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0));
    foreach (directed_vectors[i]) send_vector(directed_vectors[i]);

    for (int i = 0; i < RANDOM_VECTORS; i++) begin
      // a stretch with no idling on either side
      calm_phase = (i >= 600 && i < 900);
      send_vector(rand_vector());
    end
    calm_phase = 1'b0;
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (board.pending_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d vectors (directed extremes, zero and saturated counts, random",
             sent_count);
    $display("elements under random stalls), checked %0d results, %0d mismatches",
             board.checked_count, board.mismatch_count);
    if (board.mismatch_count == 0 && board.pending_units.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+src
src/vn_pkg.sv
src/vn_isqrt.sv
src/vn_lane_div.sv
src/vector_normalize_top.sv
sim/testbench.sv
